// File: sv/amc_pkg.sv
// Shared types and constants for the annulus metric coefficient block.
// No dependencies; used by the interfaces, the divider and the top level.
package amc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int REG_W         = 20;
    localparam int KIND_W        = 3;
    localparam int COORD_W       = 17;
    localparam int COEF_W        = 32;
    localparam int CFG_IDX_W     = 3;
    // quotient bits kept by the divider: enough to see anything above 2^31
    localparam int QUO_W         = 33;

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_kind KIND_GRAD_R = 3'd0;
    localparam t_kind KIND_GRAD_S = 3'd1;
    localparam t_kind KIND_LAP_R  = 3'd2;
    localparam t_kind KIND_LAP_S  = 3'd3;
    localparam t_kind KIND_CROSS  = 3'd4;
    localparam t_kind KIND_ZERO   = 3'd5;

    localparam t_cfg_idx CFG_INNER_RADIUS = 3'd0;
    localparam t_cfg_idx CFG_OUTER_RADIUS = 3'd1;
    localparam t_cfg_idx CFG_START_ANGLE  = 3'd2;
    localparam t_cfg_idx CFG_END_ANGLE    = 3'd3;

    // side information that rides along with a division
    typedef struct packed {
        logic neg;   // result is negative
        logic derr;  // zero divisor
        logic ovf;   // quotient known to exceed the kept bits
        logic zero;  // result forced to zero
    } t_div_tag;

endpackage

// File: sv/amc_if.sv
// Channel interfaces: item in, result out, configuration write.
// Depends on amc_pkg for field widths.
interface amc_item_if;
    logic                          valid;
    logic                          ready;
    logic [amc_pkg::KIND_W-1:0]    kind;
    logic [amc_pkg::COORD_W-1:0]   coord_r;
    logic [amc_pkg::COORD_W-1:0]   coord_s;
    modport source(output valid, kind, coord_r, coord_s, input ready);
    modport sink(input valid, kind, coord_r, coord_s, output ready);
endinterface

interface amc_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [amc_pkg::COEF_W-1:0]  coefficient;
    logic                               saturated;
    logic                               divide_error;
    modport source(output valid, coefficient, saturated, divide_error, input ready);
    modport sink(input valid, coefficient, saturated, divide_error, output ready);
endinterface

interface amc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [amc_pkg::CFG_IDX_W-1:0]    index;
    logic [amc_pkg::REG_W-1:0]        data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// File: sv/amc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on amc_pkg (t_div_tag); instantiated by the top level.
module amc_div #(
    parameter int DEN_W = 116,
    parameter int QUO_W = amc_pkg::QUO_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  amc_pkg::t_div_tag   i_tag,
    input  logic [DEN_W-1:0]    i_den,
    input  logic [DEN_W:0]      i_rem,
    output logic                o_valid,
    output amc_pkg::t_div_tag   o_tag,
    output logic [QUO_W-1:0]    o_quo
);

    logic                r_v   [QUO_W];
    amc_pkg::t_div_tag   r_tag [QUO_W];
    logic [DEN_W-1:0]    r_den [QUO_W];
    logic [DEN_W:0]      r_rem [QUO_W];
    logic [QUO_W-1:0]    r_quo [QUO_W];

    genvar j;
    generate
        for (j = 0; j < QUO_W; j++) begin : g_stage
            logic [DEN_W-1:0] w_den;
            logic [DEN_W:0]   w_rem;
            logic [QUO_W-1:0] w_quo;
            logic             w_v;
            amc_pkg::t_div_tag w_tag;
            logic [DEN_W+1:0] w_two;
            logic [DEN_W+1:0] w_dif;
            logic             w_ge;

            if (j == 0) begin : g_first
                assign w_den = i_den;
                assign w_rem = i_rem;
                assign w_quo = '0;
                assign w_v   = i_valid;
                assign w_tag = i_tag;
            end else begin : g_next
                assign w_den = r_den[j-1];
                assign w_rem = r_rem[j-1];
                assign w_quo = r_quo[j-1];
                assign w_v   = r_v[j-1];
                assign w_tag = r_tag[j-1];
            end

            assign w_two = {w_rem, 1'b0};
            assign w_ge  = (w_two >= {2'b00, w_den});
            assign w_dif = w_two - {2'b00, w_den};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else if (i_en) begin
                    r_v[j] <= w_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_tag[j] <= w_tag;
                    r_den[j] <= w_den;
                    r_rem[j] <= w_ge ? w_dif[DEN_W:0] : w_two[DEN_W:0];
                    r_quo[j] <= {w_quo[QUO_W-2:0], w_ge};
                end
            end
        end
    endgenerate

    assign o_valid = r_v[QUO_W-1];
    assign o_tag   = r_tag[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];

endmodule

// File: sv/annulus_metric_coefficients_top.sv
// Annulus metric coefficients: closed-form metric terms of the annulus map.
// Usage:
//   i_cfg   : register writes (index 0..3: inner/outer radius, start/end angle).
//             Always ready; writes beyond index 3 are dropped. Write only when
//             the pipeline is empty.
//   i_item  : kind, coord_r, coord_s; a transfer when valid and ready are high.
//   o_result: coefficient (signed Q16.F), saturated, divide_error; one result
//             per item, in order.
// From item transfer to result valid, an item passes the stages that form
// the divisor (coordinate product, radius add, two rounds of split partial
// products), a setup stage for the division, 33 one-bit divider stages and
// the output register. Throughput is one item per cycle while not stalled.
// When the receiver stalls, the whole pipeline holds and i_item.ready drops
// in the same cycle; bubbles are not squeezed out. Nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults
// (R0 = 0.5, R1 = 1.0, theta0 = 0, theta1 about 2*pi).
// Depends on amc_pkg, amc_if and amc_div.
module annulus_metric_coefficients_top #(
    parameter int FRAC_BITS = amc_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    amc_cfg_if.sink             i_cfg,
    amc_item_if.sink            i_item,
    amc_result_if.source        o_result
);

    localparam int RW     = amc_pkg::REG_W;
    localparam int QW     = amc_pkg::QUO_W;
    localparam int CW     = amc_pkg::COORD_W;
    // signed rho width and its magnitude width
    localparam int RHO_W  = ((FRAC_BITS + RW > 37) ? FRAC_BITS + RW : 37) + 2;
    localparam int MAG_R  = RHO_W - 1;
    localparam int BH     = (MAG_R + 1) / 2;
    localparam int T_W    = RW + MAG_R;
    localparam int TH     = (T_W + 1) / 2;
    localparam int THI    = T_W - TH;
    localparam int D_W    = 2 * T_W;
    localparam int K0     = 7 * FRAC_BITS - QW;
    localparam int K1     = 3 * FRAC_BITS - QW;
    localparam int K3     = 4 * FRAC_BITS - QW;
    localparam int VW     = ((D_W > K0 + 1) ? D_W : K0 + 1) + 1;
    localparam logic [VW-1:0] POW0 = {{(VW-1){1'b0}}, 1'b1} << K0;
    localparam logic [VW-1:0] POW1 = {{(VW-1){1'b0}}, 1'b1} << K1;
    localparam logic [VW-1:0] POW3 = {{(VW-1){1'b0}}, 1'b1} << K3;
    localparam logic [QW-1:0] LIM_POS = {2'b00, {(QW-2){1'b1}}};
    localparam logic [QW-1:0] LIM_NEG = {2'b01, {(QW-2){1'b0}}};

    // configuration registers
    logic [RW-1:0] r_inner, r_outer, r_start, r_end;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner <= RW'(32768);
            r_outer <= RW'(65536);
            r_start <= '0;
            r_end   <= RW'(411775);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                amc_pkg::CFG_INNER_RADIUS: r_inner <= i_cfg.data;
                amc_pkg::CFG_OUTER_RADIUS: r_outer <= i_cfg.data;
                amc_pkg::CFG_START_ANGLE:  r_start <= i_cfg.data;
                amc_pkg::CFG_END_ANGLE:    r_end   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // gam and psi; the user keeps them static while items are in flight, the block does not enforce it
    logic signed [RW:0] w_g, w_p;
    logic [RW-1:0]      w_g_mag, w_p_mag;
    logic signed [RW:0] w_g_neg, w_p_neg;

    assign w_g     = $signed({1'b0, r_outer}) - $signed({1'b0, r_inner});
    assign w_p     = $signed({r_end[RW-1], r_end}) - $signed({r_start[RW-1], r_start});
    assign w_g_neg = -w_g;
    assign w_p_neg = -w_p;
    assign w_g_mag = w_g[RW] ? w_g_neg[RW-1:0] : w_g[RW-1:0];
    assign w_p_mag = w_p[RW] ? w_p_neg[RW-1:0] : w_p[RW-1:0];

    logic r_vo;
    logic w_en;
    assign w_en         = !r_vo || o_result.ready;
    assign i_item.ready = w_en;

    // stage 1: gam * s
    logic                       r1_v;
    amc_pkg::t_kind             r1_kind;
    logic signed [RW+CW+1:0]    r1_gs;

    // stage 2: rho, operands
    logic                       r2_v;
    amc_pkg::t_kind             r2_kind;
    amc_pkg::t_div_tag          r2_tag;
    logic [RW-1:0]              r2_a;
    logic [MAG_R-1:0]           r2_b;

    // stage 3: split products
    logic                       r3_v;
    amc_pkg::t_kind             r3_kind;
    amc_pkg::t_div_tag          r3_tag;
    logic [RW+BH-1:0]           r3_plo;
    logic [RW+MAG_R-BH-1:0]     r3_phi;

    // stage 4: product sum
    logic                       r4_v;
    amc_pkg::t_kind             r4_kind;
    amc_pkg::t_div_tag          r4_tag;
    logic [T_W-1:0]             r4_t;

    // stage 5: square partials
    logic                       r5_v;
    amc_pkg::t_kind             r5_kind;
    amc_pkg::t_div_tag          r5_tag;
    logic [T_W-1:0]             r5_t;
    logic [2*THI-1:0]           r5_hh;
    logic [THI+TH-1:0]          r5_hl;
    logic [2*TH-1:0]            r5_ll;

    // stage 6: divisor
    logic                       r6_v;
    amc_pkg::t_kind             r6_kind;
    amc_pkg::t_div_tag          r6_tag;
    logic [D_W-1:0]             r6_d;

    // stage 7: divider setup
    logic                       r7_v;
    amc_pkg::t_div_tag          r7_tag;
    logic [D_W-1:0]             r7_d;
    logic [D_W:0]               r7_rem;

    // stage 2 combinational
    logic signed [RHO_W-1:0]    w_rho;
    logic signed [RHO_W-1:0]    w_rho_neg;
    logic [MAG_R-1:0]           w_rho_mag;
    logic                       w_derr;
    logic                       w_div_kind;
    amc_pkg::t_div_tag          w_tag2;

    assign w_rho = RHO_W'(r1_gs)
                 + $signed({{(RHO_W-RW){1'b0}}, r_inner} << FRAC_BITS);
    assign w_rho_neg = -w_rho;
    assign w_rho_mag = w_rho[RHO_W-1] ? w_rho_neg[MAG_R-1:0] : w_rho[MAG_R-1:0];
    assign w_derr = (r1_kind <= amc_pkg::KIND_CROSS)
                 && (w_g == '0 || w_p == '0 || w_rho == '0);
    assign w_div_kind = (r1_kind == amc_pkg::KIND_GRAD_R)
                     || (r1_kind == amc_pkg::KIND_GRAD_S)
                     || (r1_kind == amc_pkg::KIND_LAP_S);

    always_comb begin
        w_tag2.derr = w_derr;
        w_tag2.ovf  = 1'b0;
        w_tag2.zero = w_derr || !w_div_kind;
        w_tag2.neg  = (r1_kind == amc_pkg::KIND_LAP_S) && (w_g[RW] != w_rho[RHO_W-1]);
    end

    // stage 7 combinational
    logic [VW-1:0]  w_dext;
    logic [VW-1:0]  w_pow;
    amc_pkg::t_div_tag w_tag7;

    assign w_dext = VW'(r6_d);
    always_comb begin
        case (r6_kind)
            amc_pkg::KIND_GRAD_R: w_pow = POW0;
            amc_pkg::KIND_GRAD_S: w_pow = POW1;
            default:              w_pow = POW3;
        endcase
        w_tag7     = r6_tag;
        // 2^e >= 2^QW * d means the quotient does not fit
        w_tag7.ovf = (w_dext <= w_pow);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_item.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_kind <= i_item.kind;
            r1_gs   <= w_g * $signed({1'b0, i_item.coord_s});

            r2_kind <= r1_kind;
            r2_tag  <= w_tag2;
            r2_a    <= (r1_kind == amc_pkg::KIND_GRAD_R) ? w_p_mag : w_g_mag;
            r2_b    <= (r1_kind == amc_pkg::KIND_GRAD_S) ? MAG_R'(w_g_mag) : w_rho_mag;

            r3_kind <= r2_kind;
            r3_tag  <= r2_tag;
            r3_plo  <= (RW+BH)'(r2_a) * (RW+BH)'(r2_b[BH-1:0]);
            r3_phi  <= (RW+MAG_R-BH)'(r2_a) * (RW+MAG_R-BH)'(r2_b[MAG_R-1:BH]);

            r4_kind <= r3_kind;
            r4_tag  <= r3_tag;
            r4_t    <= (T_W'(r3_phi) << BH) + T_W'(r3_plo);

            r5_kind <= r4_kind;
            r5_tag  <= r4_tag;
            r5_t    <= r4_t;
            r5_hh   <= (2*THI)'(r4_t[T_W-1:TH]) * (2*THI)'(r4_t[T_W-1:TH]);
            r5_hl   <= (THI+TH)'(r4_t[T_W-1:TH]) * (THI+TH)'(r4_t[TH-1:0]);
            r5_ll   <= (2*TH)'(r4_t[TH-1:0]) * (2*TH)'(r4_t[TH-1:0]);

            r6_kind <= r5_kind;
            r6_tag  <= r5_tag;
            // only the gradient-r term squares the product
            if (r5_kind == amc_pkg::KIND_GRAD_R) begin
                r6_d <= (D_W'(r5_hh) << (2*TH)) + (D_W'(r5_hl) << (TH+1)) + D_W'(r5_ll);
            end else begin
                r6_d <= D_W'(r5_t);
            end

            r7_tag <= w_tag7;
            r7_d   <= r6_d;
            r7_rem <= w_pow[D_W:0];
        end
    end

    logic              w_dv;
    amc_pkg::t_div_tag w_dtag;
    logic [QW-1:0]     w_quo;

    amc_div #(
        .DEN_W (D_W),
        .QUO_W (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r7_v),
        .i_tag   (r7_tag),
        .i_den   (r7_d),
        .i_rem   (r7_rem),
        .o_valid (w_dv),
        .o_tag   (w_dtag),
        .o_quo   (w_quo)
    );

    // output formatting
    logic [QW-1:0]  w_lim;
    logic           w_sat;
    logic [QW-1:0]  w_mag;
    logic [QW-1:0]  w_sgn;

    assign w_lim = w_dtag.neg ? LIM_NEG : LIM_POS;
    assign w_sat = w_dtag.ovf || (w_quo > w_lim);
    assign w_mag = w_sat ? w_lim : w_quo;
    assign w_sgn = w_dtag.neg ? (~w_mag + QW'(1)) : w_mag;

    logic signed [amc_pkg::COEF_W-1:0] r_coef;
    logic                              r_sat;
    logic                              r_derr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_en) begin
            r_vo <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_derr <= w_dtag.derr;
            if (w_dtag.zero) begin
                r_coef <= '0;
                r_sat  <= 1'b0;
            end else begin
                r_coef <= $signed(w_sgn[amc_pkg::COEF_W-1:0]);
                r_sat  <= w_sat;
            end
        end
    end

    assign o_result.valid        = r_vo;
    assign o_result.coefficient  = r_coef;
    assign o_result.saturated    = r_sat;
    assign o_result.divide_error = r_derr;

    a_derr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.divide_error
        |-> (o_result.coefficient == '0) && !o_result.saturated)
        else $error("divide error with nonzero result");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.saturated
        |-> (o_result.coefficient == 32'sh7fffffff)
         || (o_result.coefficient == 32'sh80000000))
        else $error("saturated result not at a limit");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && !o_result.ready |=> $stable(r7_d) && $stable(r7_v))
        else $error("pipeline moved during output stall");

endmodule
